/* rtl/fixed_block_pool_allocator_core_defines.svh */
// Assertion macros shared by the block pool allocator RTL.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_DEFINES_SVH

// Check that a condition implies a property in the same cycle.
`define FBPA_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("fbpa: same-cycle check failed");

// Check that a condition implies a property in the following cycle.
`define FBPA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("fbpa: next-cycle check failed");

`endif

/* rtl/fbpa_pkg.sv */
// Types, widths and codes of the fixed block pool allocator.
package fbpa_pkg;

   // Pool geometry
   localparam int POOL_BLOCKS = 1024;
   localparam int IDX_W       = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
   localparam int LINK_W      = IDX_W + 1;
   localparam int ENTRY_W     = LINK_W + 1;

   // Field widths
   localparam int ADDR_W      = 32;
   localparam int SIZE_W      = 17;
   localparam int COUNT_W     = 11;
   localparam int STATUS_W    = 3;
   localparam int CSR_IDX_W   = 2;
   localparam int TOTAL_W     = COUNT_W + SIZE_W;
   localparam int PROD_W      = IDX_W + SIZE_W;

   // Divider sizing
   localparam int DIV_STEPS   = ADDR_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

   // End-of-list marker: top link bit set
   localparam logic [LINK_W-1:0] LINK_NONE = {1'b1, {IDX_W{1'b0}}};

   // Reset values of the registers
   localparam logic [ADDR_W-1:0]  POOL_BASE_RESET   = ADDR_W'(65536);
   localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RESET  = SIZE_W'(16);
   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = COUNT_W'(1024);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT = 2'd2;

   // Request kinds
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NULL   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_DOUBLE = 3'd4;

   // Sequencer states
   typedef enum logic [2:0] {
      FSM_SWEEP,
      FSM_IDLE,
      FSM_ALLOC,
      FSM_FREE_CHK,
      FSM_FREE_DIV,
      FSM_FREE_UPD
   } fbpa_state_type;

   // Divider result
   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] quotient;
      logic [SIZE_W-1:0] remainder;
   } div_result_type;

endpackage

/* rtl/fbpa_divider.sv */
// Restoring divider for the free path: one quotient bit per cycle.
module fbpa_divider import fbpa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ADDR_W-1:0] dividend,
   input  logic [SIZE_W-1:0] divisor,
   output div_result_type    result
);

   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [ADDR_W-1:0]    quo_ff, quo_in;
   logic [SIZE_W-1:0]    rem_ff, rem_in;
   logic [SIZE_W-1:0]    div_ff;
   logic                 done_ff, done_in;
   logic [SIZE_W:0]      shifted;

   // Shift in the next dividend bit and try to subtract
   assign shifted = {rem_ff, quo_ff[ADDR_W-1]};

   always_comb begin
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      if (start) begin
         count_in = DIV_CNT_W'(DIV_STEPS);
         quo_in   = dividend;
         rem_in   = '0;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == DIV_CNT_W'(1));
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = SIZE_W'(shifted - {1'b0, div_ff});
            quo_in = {quo_ff[ADDR_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[SIZE_W-1:0];
            quo_in = {quo_ff[ADDR_W-2:0], 1'b0};
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

   // Datapath, no reset needed
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

endmodule

/* rtl/fixed_block_pool_allocator_core.sv */
// Top level of the fixed block pool allocator: sequencer, link memory, registers.
//
// Hands out and takes back fixed-size blocks. Each request accepted at start
// high with busy low gives exactly one result, shown for one cycle with
// rsp_strobe, unless a write of block_size or block_count abandons it; the
// receiver cannot stall it. An allocate that succeeds is answered from ALLOC,
// a request answered at once (pool empty, null address, address below the
// base) from idle, and a free that reaches the block check from FREE_UPD after
// FREE_CHK and FREE_DIV, paced by the one-bit-per-cycle divider that turns the
// address offset into a block index; rejected frees exit earlier. A new request
// may be accepted in the cycle the strobe is shown. The free list and the
// allocation marks share one single-port-write, registered-read memory of
// POOL_BLOCKS entries. After reset, and after each write of block_size or
// block_count, a clearing pass over all POOL_BLOCKS entries rebuilds the list;
// busy stays high meanwhile, register writes are still taken.
module fixed_block_pool_allocator_core import fbpa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_op,
   input  logic [ADDR_W-1:0]    req_address,
   output logic                 rsp_strobe,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [ADDR_W-1:0]    rsp_block_address,
   output logic [COUNT_W-1:0]   rsp_used,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data
);

`include "fixed_block_pool_allocator_core_defines.svh"

   // Registers
   logic [ADDR_W-1:0]  pool_base_ff;
   logic [SIZE_W-1:0]  block_size_ff;
   logic [COUNT_W-1:0] block_count_ff;
   fbpa_state_type     state_ff, state_in;
   logic [IDX_W-1:0]   sweep_ff, sweep_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [COUNT_W-1:0] used_ff, used_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]  offset_ff, offset_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic               rsp_strobe_ff, rsp_load;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]  rsp_address_ff, rsp_address_in;
   logic [COUNT_W-1:0] rsp_used_ff, rsp_used_in;

   // Memory: {allocated mark, next link}
   logic [ENTRY_W-1:0] pool_mem [POOL_BLOCKS];
   logic [ENTRY_W-1:0] rd_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr, mem_raddr;
   logic [ENTRY_W-1:0] mem_wdata;

   // Divider
   logic               div_start;
   div_result_type     div_res;

   // Derived values
   logic [SIZE_W-1:0]  eff_size;
   logic [COUNT_W-1:0] eff_count;
   logic               rebuild;
   logic               sweep_last;
   logic               head_empty;
   logic [LINK_W-1:0]  sweep_link;
   logic [IDX_W-1:0]   sweep_next;
   logic               div_bad;

   assign eff_size   = (block_size_ff == '0) ? SIZE_W'(1) : block_size_ff;
   assign eff_count  = (32'(block_count_ff) > 32'(POOL_BLOCKS)) ?
                       COUNT_W'(POOL_BLOCKS) : block_count_ff;
   assign rebuild    = csr_write_enable &&
                       (csr_index == CSR_BLOCK_SIZE || csr_index == CSR_BLOCK_COUNT);
   assign sweep_last = (sweep_ff == IDX_W'(POOL_BLOCKS - 1));
   assign head_empty = head_ff[IDX_W];
   assign sweep_next = sweep_ff + 1'b1;
   assign sweep_link = (32'(sweep_ff) + 32'd1 < 32'(eff_count)) ?
                       {1'b0, sweep_next} : LINK_NONE;
   assign div_bad    = (div_res.remainder != '0) ||
                       (div_res.quotient >= ADDR_W'(POOL_BLOCKS));

   // Operands prepared while idle
   assign offset_in  = req_address - pool_base_ff;
   assign total_in   = TOTAL_W'(eff_count) * TOTAL_W'(eff_size);
   assign prod_in    = PROD_W'(head_ff[IDX_W-1:0]) * PROD_W'(eff_size);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_SWEEP: begin
            if (sweep_last) state_in = FSM_IDLE;
         end
         FSM_IDLE: begin
            if (start) begin
               if (req_op == OP_ALLOC) begin
                  if (!head_empty) state_in = FSM_ALLOC;
               end else if (req_address != '0 && req_address >= pool_base_ff) begin
                  state_in = FSM_FREE_CHK;
               end
            end
         end
         FSM_ALLOC: state_in = FSM_IDLE;
         FSM_FREE_CHK: begin
            if (offset_ff >= ADDR_W'(total_ff)) state_in = FSM_IDLE;
            else state_in = FSM_FREE_DIV;
         end
         FSM_FREE_DIV: begin
            if (div_res.done) begin
               if (div_bad) state_in = FSM_IDLE;
               else state_in = FSM_FREE_UPD;
            end
         end
         FSM_FREE_UPD: state_in = FSM_IDLE;
         default: state_in = FSM_IDLE;
      endcase
      if (rebuild) state_in = FSM_SWEEP;
   end

   // Outputs, memory accesses and register updates
   always_comb begin
      mem_we         = 1'b0;
      mem_waddr      = sweep_ff;
      mem_wdata      = {1'b0, sweep_link};
      mem_raddr      = head_ff[IDX_W-1:0];
      div_start      = 1'b0;
      head_in        = head_ff;
      used_in        = used_ff;
      sweep_in       = sweep_ff;
      idx_in         = idx_ff;
      rsp_load       = 1'b0;
      rsp_status_in  = STATUS_OK;
      rsp_address_in = '0;
      rsp_used_in    = used_ff;
      case (state_ff)
         FSM_SWEEP: begin
            // Chain blocks in ascending order and clear the marks
            mem_we   = 1'b1;
            sweep_in = sweep_next;
            if (sweep_last) begin
               head_in = (eff_count != '0) ? '0 : LINK_NONE;
            end
         end
         FSM_IDLE: begin
            // Answer the trivial cases at once
            if (start) begin
               if (req_op == OP_ALLOC) begin
                  if (head_empty) begin
                     rsp_load      = 1'b1;
                     rsp_status_in = STATUS_EMPTY;
                  end
               end else if (req_address == '0) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = STATUS_NULL;
               end else if (req_address < pool_base_ff) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = STATUS_BAD;
               end
            end
         end
         FSM_ALLOC: begin
            // Pop the head, mark it used
            mem_we         = 1'b1;
            mem_waddr      = head_ff[IDX_W-1:0];
            mem_wdata      = {1'b1, rd_ff[LINK_W-1:0]};
            head_in        = rd_ff[LINK_W-1:0];
            used_in        = used_ff + 1'b1;
            rsp_load       = 1'b1;
            rsp_status_in  = STATUS_OK;
            rsp_address_in = pool_base_ff + ADDR_W'(prod_ff);
            rsp_used_in    = used_in;
         end
         FSM_FREE_CHK: begin
            if (offset_ff >= ADDR_W'(total_ff)) begin
               rsp_load      = 1'b1;
               rsp_status_in = STATUS_BAD;
            end else begin
               div_start = 1'b1;
            end
         end
         FSM_FREE_DIV: begin
            // Read the entry of the block as soon as its index is known
            mem_raddr = div_res.quotient[IDX_W-1:0];
            idx_in    = div_res.quotient[IDX_W-1:0];
            if (div_res.done && div_bad) begin
               rsp_load      = 1'b1;
               rsp_status_in = STATUS_BAD;
            end
         end
         FSM_FREE_UPD: begin
            rsp_load = 1'b1;
            if (!rd_ff[LINK_W]) begin
               rsp_status_in = STATUS_DOUBLE;
            end else begin
               // Unmark and push onto the list head
               mem_we        = 1'b1;
               mem_waddr     = idx_ff;
               mem_wdata     = {1'b0, head_ff};
               head_in       = {1'b0, idx_ff};
               used_in       = (used_ff != '0) ? used_ff - 1'b1 : '0;
               rsp_status_in = STATUS_OK;
               rsp_used_in   = used_in;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
      // A geometry write restarts the clearing pass
      if (rebuild) begin
         mem_we   = 1'b0;
         sweep_in = '0;
         used_in  = '0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= POOL_BASE_RESET;
         block_size_ff  <= BLOCK_SIZE_RESET;
         block_count_ff <= BLOCK_COUNT_RESET;
         state_ff       <= FSM_SWEEP;
         sweep_ff       <= '0;
         head_ff        <= LINK_NONE;
         used_ff        <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_POOL_BASE:   pool_base_ff   <= csr_data;
               CSR_BLOCK_SIZE:  block_size_ff  <= csr_data[SIZE_W-1:0];
               CSR_BLOCK_COUNT: block_count_ff <= csr_data[COUNT_W-1:0];
               default:         pool_base_ff   <= pool_base_ff;
            endcase
         end
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         head_ff       <= head_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_load;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (state_ff == FSM_IDLE) begin
         offset_ff <= offset_in;
         total_ff  <= total_in;
         prod_ff   <= prod_in;
      end
      if (rsp_load) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_address_ff <= rsp_address_in;
         rsp_used_ff    <= rsp_used_in;
      end
   end

   // Pool memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pool_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= pool_mem[mem_raddr];
   end

   fbpa_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (offset_ff),
      .divisor  (eff_size),
      .result   (div_res)
   );

   assign busy              = (state_ff != FSM_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_address_ff;
   assign rsp_used          = rsp_used_ff;

   // Checks
   `FBPA_ASSERT_SAME(a_addr_only_on_ok, clock, reset, rsp_strobe && rsp_status != STATUS_OK, rsp_block_address == '0)
   `FBPA_ASSERT_NEXT(a_request_progresses, clock, reset, start && !busy, busy || rsp_strobe)
   `FBPA_ASSERT_SAME(a_empty_means_all_used, clock, reset, state_ff == FSM_IDLE && head_empty, used_ff == eff_count)
   `FBPA_ASSERT_SAME(a_alloc_from_nonempty, clock, reset, state_ff == FSM_ALLOC, !head_empty)

endmodule
